// ----- src/ick_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ick_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TRAILER_BYTES   = 12;
    localparam int LEN_W           = 32;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_FORMAT_MODE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BYTES   = 1'b1;

    localparam logic       MODE_JPEG          = 1'b0;
    localparam logic       FORMAT_MODE_RESET  = 1'b1;
    localparam logic [31:0] MAX_BYTES_RESET   = 32'd8388608;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int JPEG_MIN_BYTES = 4;
    localparam int PNG_MIN_BYTES  = 32;
    localparam int SIG_JPEG_BYTES = 2;
    localparam int SIG_PNG_BYTES  = 8;

    localparam logic [7:0] JPEG_SOI [SIG_JPEG_BYTES] = '{8'hFF, 8'hD8};
    localparam logic [7:0] JPEG_EOI [2]              = '{8'hFF, 8'hD9};
    localparam logic [7:0] PNG_SIG  [SIG_PNG_BYTES]  =
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] PNG_TRAILER [TRAILER_BYTES] =
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h49, 8'h45, 8'h4E, 8'h44,
          8'hAE, 8'h42, 8'h60, 8'h82};

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_SIZE    = 3'd1,
        ERR_SIG     = 3'd2,
        ERR_TRAILER = 3'd3,
        ERR_CHUNK   = 3'd4,
        ERR_CRC     = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_CRC  = 2'd3
    } t_phase;

    typedef struct packed {
        logic       go;
        logic [7:0] data;
        logic       last;
    } t_step;

    typedef struct packed {
        t_err err;
        logic open;
    } t_walk_status;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/ick_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ick_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data,
    input  wire logic          i_last,
    input  wire logic          i_out_free,
    output ick_pkg::t_step     o_step
);
    import ick_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       go;

    // a non-final byte never needs the result register
    assign go      = r_valid && (!r_last || i_out_free);
    assign o_ready = !r_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_step = '{go: go, data: r_data, last: r_last};

endmodule

`default_nettype wire

// ----- src/ick_chunk_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ick_chunk_walk (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ick_pkg::t_step   i_step,
    input  wire logic             i_walk_en,
    output ick_pkg::t_walk_status o_status
);
    import ick_pkg::*;

    localparam logic [LEN_W-1:0] FIELD_BYTES = LEN_W'(4);

    t_phase           r_phase,  n_phase;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic [LEN_W-1:0] r_len,    n_len;
    logic [31:0]      r_crc,    n_crc;
    logic [31:0]      r_crc_rx, n_crc_rx;
    t_err             r_err,    n_err;
    logic [LEN_W-1:0] remain_dec;
    logic             field_done;

    assign remain_dec = r_remain - LEN_W'(1);
    assign field_done = (r_remain == LEN_W'(1));

    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        n_len    = r_len;
        n_crc    = r_crc;
        n_crc_rx = r_crc_rx;
        n_err    = r_err;
        if (i_step.go && i_walk_en) begin
            n_remain = remain_dec;
            case (r_phase)
                PH_LEN: begin
                    n_len = {r_len[LEN_W-9:0], i_step.data};
                    if (field_done) begin
                        n_phase  = PH_TYPE;
                        n_remain = FIELD_BYTES;
                        n_crc    = CRC_INIT;
                    end
                end
                PH_TYPE: begin
                    n_crc = crc32_byte(r_crc, i_step.data);
                    if (field_done) begin
                        n_crc_rx = '0;
                        if (r_len == '0) begin
                            n_phase  = PH_CRC;
                            n_remain = FIELD_BYTES;
                        end else begin
                            n_phase  = PH_DATA;
                            n_remain = r_len;
                        end
                    end
                end
                PH_DATA: begin
                    n_crc = crc32_byte(r_crc, i_step.data);
                    if (field_done) begin
                        n_phase  = PH_CRC;
                        n_remain = FIELD_BYTES;
                    end
                end
                PH_CRC: begin
                    n_crc_rx = {r_crc_rx[23:0], i_step.data};
                    if (field_done) begin
                        if (r_err == ERR_NONE && (~r_crc) != n_crc_rx) begin
                            n_err = ERR_CRC;
                        end
                        n_phase  = PH_LEN;
                        n_remain = FIELD_BYTES;
                        n_len    = '0;
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase
        end
    end

    always_comb begin
        o_status.err  = n_err;
        o_status.open = (n_phase != PH_LEN) || (n_remain != FIELD_BYTES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.go && i_step.last)) begin
            r_phase  <= PH_LEN;
            r_remain <= FIELD_BYTES;
            r_len    <= '0;
            r_crc    <= CRC_INIT;
            r_crc_rx <= '0;
            r_err    <= ERR_NONE;
        end else begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_len    <= n_len;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

// ----- src/ick_verdict.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ick_verdict #(
    parameter int COUNT_WIDTH = ick_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ick_pkg::t_step        i_step,
    input  wire ick_pkg::t_walk_status i_walk,
    input  wire logic                  i_format_mode,
    input  wire logic [31:0]           i_max_bytes,
    input  wire logic                  i_out_ready,
    output logic                       o_out_free,
    output logic                       o_walk_en,
    output logic                       o_valid,
    output logic                       o_accepted,
    output logic [2:0]                 o_error_code
);
    import ick_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_sig_bad, n_sig_bad;
    logic [7:0]             r_tail [TRAILER_BYTES];
    logic [7:0]             n_tail [TRAILER_BYTES];
    logic                   r_out_valid;
    logic                   r_accepted;
    t_err                   r_err;
    logic                   sig_miss;
    logic                   trailer_ok;
    logic                   eoi_ok;
    t_err                   code;

    assign o_out_free = !r_out_valid || i_out_ready;
    assign o_walk_en  = (r_count >= COUNT_WIDTH'(SIG_PNG_BYTES));

    always_comb begin
        sig_miss = 1'b0;
        if (i_format_mode == MODE_JPEG) begin
            if (r_count < COUNT_WIDTH'(SIG_JPEG_BYTES)) begin
                sig_miss = (i_step.data != JPEG_SOI[r_count[0]]);
            end
        end else begin
            if (r_count < COUNT_WIDTH'(SIG_PNG_BYTES)) begin
                sig_miss = (i_step.data != PNG_SIG[r_count[2:0]]);
            end
        end
        n_sig_bad = r_sig_bad || sig_miss;
        n_count   = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_WIDTH'(1);
    end

    always_comb begin
        for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
            n_tail[i] = r_tail[i+1];
        end
        n_tail[TRAILER_BYTES-1] = i_step.data;
    end

    always_comb begin
        trailer_ok = 1'b1;
        for (int i = 0; i < TRAILER_BYTES; i++) begin
            if (n_tail[i] != PNG_TRAILER[i]) begin
                trailer_ok = 1'b0;
            end
        end
        eoi_ok = (n_tail[TRAILER_BYTES-2] == JPEG_EOI[0])
              && (n_tail[TRAILER_BYTES-1] == JPEG_EOI[1]);
    end

    always_comb begin
        code = ERR_NONE;
        if (32'(n_count) > i_max_bytes) begin
            code = ERR_SIZE;
        end else if (i_format_mode == MODE_JPEG) begin
            if (n_count < COUNT_WIDTH'(JPEG_MIN_BYTES)) begin
                code = ERR_SIZE;
            end else if (n_sig_bad) begin
                code = ERR_SIG;
            end else if (!eoi_ok) begin
                code = ERR_TRAILER;
            end
        end else begin
            if (n_count < COUNT_WIDTH'(PNG_MIN_BYTES)) begin
                code = ERR_SIZE;
            end else if (n_sig_bad) begin
                code = ERR_SIG;
            end else if (!trailer_ok) begin
                code = ERR_TRAILER;
            end else if (i_walk.err != ERR_NONE) begin
                code = i_walk.err;
            end else if (i_walk.open) begin
                code = ERR_CHUNK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.go && i_step.last)) begin
            r_count   <= '0;
            r_sig_bad <= 1'b0;
        end else if (i_step.go) begin
            r_count   <= n_count;
            r_sig_bad <= n_sig_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.go) begin
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step.go && i_step.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.go && i_step.last) begin
            r_accepted <= (code == ERR_NONE);
            r_err      <= code;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_accepted   = r_accepted;
    assign o_error_code = r_err;

endmodule

`default_nettype wire

// ----- src/image_container_checker_top.sv -----
// Container checker for JPEG and PNG files streamed one byte per transfer, with
// tlast on the final byte. Every byte is taken in one cycle and bytes may follow
// back to back, but a final byte waits on an untaken verdict; the rate is set by
// the byte-wide CRC-32 update of the chunk walker, which finishes each byte in a
// single cycle. One verdict transfer is produced per file and holds in an output
// register so the next file can stream in while it waits. In PNG mode the chunk
// walk (big-endian length, type, data, CRC-32 over type and data) must end
// exactly at the final byte, and the first CRC mismatch is kept. The byte count
// saturates at its width. Configuration writes take effect at once and belong
// between files. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module image_container_checker_top #(
    parameter int COUNT_WIDTH = ick_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [0] accepted, [3:1] error_code
    input  wire logic                           i_cfg_we,
    input  wire logic [ick_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [ick_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ick_pkg::*;

    logic         r_format_mode;
    logic [31:0]  r_max_bytes;
    t_step        step;
    t_walk_status walk;
    logic         out_free;
    logic         walk_en;
    logic         accepted;
    logic [2:0]   error_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= FORMAT_MODE_RESET;
            r_max_bytes   <= MAX_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FORMAT_MODE: r_format_mode <= i_cfg_wdata[0];
                CFG_MAX_BYTES:   r_max_bytes   <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    ick_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_out_free (out_free),
        .o_step     (step)
    );

    ick_chunk_walk u_chunk_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_walk_en (walk_en),
        .o_status  (walk)
    );

    ick_verdict #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_verdict (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_walk        (walk),
        .i_format_mode (r_format_mode),
        .i_max_bytes   (r_max_bytes),
        .i_out_ready   (m_axis_tready),
        .o_out_free    (out_free),
        .o_walk_en     (walk_en),
        .o_valid       (m_axis_tvalid),
        .o_accepted    (accepted),
        .o_error_code  (error_code)
    );

    assign m_axis_tdata = {4'd0, error_code, accepted};

endmodule

`default_nettype wire

// ----- src/ick_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ick_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict dropped or changed while stalled");

    a_accept_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == 3'd0)))
        else $error("accepted flag disagrees with error code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] <= 3'd5) && (m_axis_tdata[7:4] == 4'd0))
        else $error("error code out of range");

    a_verdict_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("verdict without a final byte transfer");

endmodule

bind image_container_checker_top ick_checker u_ick_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ick_pkg::*;

    localparam int          CNT_W          = 16;
    localparam logic [31:0] CNT_MAX        = (32'd1 << CNT_W) - 32'd1;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          RANDOM_BYTES   = 240;
    localparam int          RANDOM_FILES   = 12;

    typedef struct packed {
        logic ok;
        t_err code;
    } verdict_t;

    typedef enum int {
        DAMAGE_FLIP,
        DAMAGE_DROP,
        DAMAGE_INSERT,
        DAMAGE_HUGE_LEN
    } damage_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] data_byte
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;   // [0] accepted, [3:1] error_code
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // container checker state as the block should hold it
    logic        fmt_mode;
    logic [31:0] size_limit;
    logic [31:0] file_len;
    logic        sig_bad;
    logic [7:0]  tail [TRAILER_BYTES];
    t_phase      walk_phase;
    logic [31:0] field_left;
    logic [31:0] chunk_len;
    logic [31:0] crc_acc;
    logic [31:0] crc_got;
    t_err        walk_err;

    verdict_t    verdict_q [$];
    logic [7:0]  file_q [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int n_fail       = 0;
    int bytes_sent   = 0;
    int files_done   = 0;

    image_container_checker_top #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = {1'b0, c[31:1]} ^ CRC_POLY;
            end else begin
                c = {1'b0, c[31:1]};
            end
        end
        return c;
    endfunction

    function automatic void clear_file();
        file_len = '0;
        sig_bad  = 1'b0;
        for (int i = 0; i < TRAILER_BYTES; i++) tail[i] = '0;
        walk_phase = PH_LEN;
        field_left = 32'd4;
        chunk_len  = '0;
        crc_acc    = CRC_INIT;
        crc_got    = '0;
        walk_err   = ERR_NONE;
    endfunction

    function automatic void walk_chunk_byte(input logic [7:0] b);
        case (walk_phase)
            PH_LEN: begin
                chunk_len  = {chunk_len[23:0], b};
                field_left = field_left - 1;
                if (field_left == 0) begin
                    walk_phase = PH_TYPE;
                    field_left = 32'd4;
                    crc_acc    = CRC_INIT;
                end
            end
            PH_TYPE: begin
                crc_acc    = crc_update(crc_acc, b);
                field_left = field_left - 1;
                if (field_left == 0) begin
                    if (chunk_len == 0) begin
                        walk_phase = PH_CRC;
                        field_left = 32'd4;
                    end else begin
                        walk_phase = PH_DATA;
                        field_left = chunk_len;
                    end
                    crc_got = '0;
                end
            end
            PH_DATA: begin
                crc_acc    = crc_update(crc_acc, b);
                field_left = field_left - 1;
                if (field_left == 0) begin
                    walk_phase = PH_CRC;
                    field_left = 32'd4;
                end
            end
            default: begin
                crc_got    = {crc_got[23:0], b};
                field_left = field_left - 1;
                if (field_left == 0) begin
                    if (walk_err == ERR_NONE && ~crc_acc != crc_got) walk_err = ERR_CRC;
                    walk_phase = PH_LEN;
                    field_left = 32'd4;
                    chunk_len  = '0;
                end
            end
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        logic [31:0] pos;
        logic        tail_ok;
        t_err        code;
        verdict_t    v;
        pos = file_len;
        if (fmt_mode == MODE_JPEG) begin
            if (pos < SIG_JPEG_BYTES && b != JPEG_SOI[pos[0]]) sig_bad = 1'b1;
        end else begin
            if (pos < SIG_PNG_BYTES && b != PNG_SIG[pos[2:0]]) sig_bad = 1'b1;
        end
        if (pos >= SIG_PNG_BYTES) walk_chunk_byte(b);
        for (int i = 0; i < TRAILER_BYTES - 1; i++) tail[i] = tail[i+1];
        tail[TRAILER_BYTES-1] = b;
        if (file_len < CNT_MAX) file_len = file_len + 1;
        if (!last) return;

        tail_ok = 1'b1;
        for (int i = 0; i < TRAILER_BYTES; i++) begin
            if (tail[i] != PNG_TRAILER[i]) tail_ok = 1'b0;
        end
        code = ERR_NONE;
        if (file_len > size_limit) begin
            code = ERR_SIZE;
        end else if (fmt_mode == MODE_JPEG) begin
            if (file_len < JPEG_MIN_BYTES) code = ERR_SIZE;
            else if (sig_bad) code = ERR_SIG;
            else if (tail[TRAILER_BYTES-2] != JPEG_EOI[0] ||
                     tail[TRAILER_BYTES-1] != JPEG_EOI[1]) code = ERR_TRAILER;
        end else begin
            if (file_len < PNG_MIN_BYTES) code = ERR_SIZE;
            else if (sig_bad) code = ERR_SIG;
            else if (!tail_ok) code = ERR_TRAILER;
            else if (walk_err != ERR_NONE) code = walk_err;
            else if (walk_phase != PH_LEN || field_left != 32'd4) code = ERR_CHUNK;
        end
        v.ok   = (code == ERR_NONE);
        v.code = code;
        verdict_q.push_back(v);
        files_done++;
        clear_file();
    endfunction

    function automatic void push_be32(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
    endfunction

    function automatic void build_png(input int n_chunks, input int max_data);
        logic [31:0] len;
        logic [31:0] crc;
        logic [7:0]  b;
        file_q.delete();
        for (int i = 0; i < SIG_PNG_BYTES; i++) file_q.push_back(PNG_SIG[i]);
        repeat (n_chunks) begin
            len = $urandom_range(max_data);
            push_be32(len);
            crc = CRC_INIT;
            for (int i = 0; i < 4 + len; i++) begin
                b   = 8'($urandom);
                crc = crc_update(crc, b);
                file_q.push_back(b);
            end
            push_be32(~crc);
        end
        for (int i = 0; i < TRAILER_BYTES; i++) file_q.push_back(PNG_TRAILER[i]);
    endfunction

    function automatic void build_jpeg(input int len);
        file_q.delete();
        file_q.push_back(JPEG_SOI[0]);
        file_q.push_back(JPEG_SOI[1]);
        repeat (len - 4) file_q.push_back(8'($urandom));
        file_q.push_back(JPEG_EOI[0]);
        file_q.push_back(JPEG_EOI[1]);
    endfunction

    function automatic void build_noise(input int len);
        file_q.delete();
        repeat (len) file_q.push_back(8'($urandom));
    endfunction

    function automatic void damage_file(input damage_t how);
        int at;
        at = $urandom_range(file_q.size() - 1);
        case (how)
            DAMAGE_FLIP:   file_q[at] = file_q[at] ^ 8'($urandom_range(1, 255));
            DAMAGE_DROP:   file_q.delete(at);
            DAMAGE_INSERT: file_q.insert(at, 8'($urandom));
            default:       if (file_q.size() > 8) file_q[8] = 8'hFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(3))
            0:       return MAX_BYTES_RESET;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(20, 80);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic set_idling(input int tx, input int rx);
        tx_idle_pct = tx;
        rx_stall_pct <= rx;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_range(input int lo, input int hi);
        for (int i = lo; i < hi; i++) send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic send_file();
        send_range(0, file_q.size());
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_FORMAT_MODE) fmt_mode = value[0];
        else size_limit = value;
    endtask

    task automatic test_reset_config();
        build_png(1, 0);
        send_file();
        build_noise(1);
        send_file();
        build_png(1, 0);
        file_q.delete(20);
        send_file();
        build_png(2, 16);
        send_file();
    endtask

    task automatic test_png_checks();
        int len1;
        build_png(1, 8);
        file_q[3] = file_q[3] ^ 8'h20;
        send_file();
        build_png(1, 8);
        file_q[file_q.size()-1] = file_q[file_q.size()-1] ^ 8'h01;
        send_file();
        build_png(1, 8);
        file_q[file_q.size()-13] = file_q[file_q.size()-13] ^ 8'h01;
        send_file();
        // both chunks carry a bad CRC: the first failure is kept
        build_png(2, 8);
        len1 = int'(file_q[11]);
        file_q[19+len1] = file_q[19+len1] ^ 8'h80;
        file_q[file_q.size()-13] = file_q[file_q.size()-13] ^ 8'h01;
        send_file();
        build_png(1, 8);
        file_q[11] = file_q[11] + 8'd12;
        send_file();
        build_png(1, 8);
        file_q[8] = 8'hFF;
        send_file();
    endtask

    task automatic test_jpeg_checks();
        cfg_write(CFG_FORMAT_MODE, 32'(MODE_JPEG));
        build_jpeg(4);
        send_file();
        build_jpeg(20);
        send_file();
        build_jpeg(4);
        file_q.delete(2);
        send_file();
        build_jpeg(10);
        file_q[1] = file_q[1] ^ 8'h01;
        send_file();
        build_jpeg(10);
        file_q[9] = file_q[9] ^ 8'h10;
        send_file();
        build_png(1, 4);
        send_file();
    endtask

    task automatic test_size_limit();
        cfg_write(CFG_MAX_BYTES, 32'd40);
        build_jpeg(40);
        send_file();
        build_jpeg(41);
        send_file();
        cfg_write(CFG_MAX_BYTES, 32'd1);
        build_jpeg(4);
        send_file();
        cfg_write(CFG_MAX_BYTES, 32'hFFFF_FFFF);
        build_jpeg(30);
        send_file();
        cfg_write(CFG_FORMAT_MODE, 32'(~MODE_JPEG));
        cfg_write(CFG_MAX_BYTES, 32'd32);
        build_png(1, 0);
        send_file();
        cfg_write(CFG_MAX_BYTES, MAX_BYTES_RESET);
    endtask

    task automatic test_mode_switch_mid_file();
        // first byte judged as PNG, the rest as JPEG
        build_jpeg(12);
        send_range(0, 1);
        cfg_write(CFG_FORMAT_MODE, 32'(MODE_JPEG));
        send_range(1, file_q.size());
        // SOI judged as JPEG, the rest of the signature as PNG
        build_png(1, 4);
        file_q[0] = JPEG_SOI[0];
        file_q[1] = JPEG_SOI[1];
        send_range(0, 2);
        cfg_write(CFG_FORMAT_MODE, 32'(~MODE_JPEG));
        send_range(2, file_q.size());
    endtask

    task automatic test_output_backpressure();
        set_idling(0, 0);
        cfg_write(CFG_FORMAT_MODE, 32'(MODE_JPEG));
        hold_trigger <= hold_trigger + 1;
        repeat (12) begin
            build_jpeg(4);
            send_file();
        end
        wait_drain();
    endtask

    task automatic run_random_file();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) cfg_write(CFG_FORMAT_MODE, 32'($urandom_range(1)));
        else if (pick < 14) cfg_write(CFG_MAX_BYTES, pick_limit());
        pick = $urandom_range(99);
        if (pick < 75) begin
            if (fmt_mode == MODE_JPEG) build_jpeg($urandom_range(4, 40));
            else build_png($urandom_range(1, 3), $urandom_range(12));
            if ($urandom_range(99) < 30) damage_file(damage_t'($urandom_range(3)));
        end else if (pick < 90) begin
            if (fmt_mode == MODE_JPEG) build_png($urandom_range(3), $urandom_range(12));
            else build_jpeg($urandom_range(4, 40));
        end else begin
            build_noise($urandom_range(1, 40));
        end
        send_file();
    endtask

    task automatic test_random_traffic();
        int phase_bytes;
        int phase_files;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       set_idling(0, 0);
                1:       set_idling(85, 0);
                2:       set_idling(0, 85);
                default: set_idling(32, 32);
            endcase
            phase_bytes = bytes_sent + RANDOM_BYTES / 4;
            phase_files = files_done + RANDOM_FILES / 4;
            while (bytes_sent < phase_bytes || files_done < phase_files) run_random_file();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict: expected none, actual accepted %0b error_code %0d",
                         $time, m_axis_tdata[0], m_axis_tdata[3:1]);
                n_fail++;
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.ok) begin
                    $display("%0t: accepted mismatch: expected %0b actual %0b",
                             $time, want.ok, m_axis_tdata[0]);
                    n_fail++;
                end
                if (m_axis_tdata[3:1] !== want.code) begin
                    $display("%0t: error_code mismatch: expected %0d actual %0d",
                             $time, want.code, m_axis_tdata[3:1]);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAIL image_container_checker_top");
            $finish;
        end
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        i_rst_n       <= 1'b0;
        fmt_mode   = FORMAT_MODE_RESET;
        size_limit = MAX_BYTES_RESET;
        clear_file();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(20, 20);
        test_reset_config();
        test_png_checks();
        test_jpeg_checks();
        test_size_limit();
        test_mode_switch_mid_file();
        test_output_backpressure();
        test_random_traffic();

        wait_drain();
        if (n_fail == 0) begin
            $display("PASS image_container_checker_top");
        end else begin
            $display("FAIL image_container_checker_top");
        end
        $finish;
    end

endmodule
